/* sv/tts_pkg.sv */
// shared types, command codes and widths of the tick task scheduler table
package tts_pkg;

   // field widths
   localparam int TAG_W    = 8;
   localparam int PERIOD_W = 24;
   localparam int SLOT_W   = 3;
   localparam int COUNT_W  = 4;

   // default table depth
   localparam int DEFAULT_TABLE_SLOTS = 8;

   // command codes
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   // one table entry, occupancy is kept by the fill count
   typedef struct packed {
      logic [TAG_W-1:0]    tag;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] countdown;
      logic                repeat_flag;
   } entry_type;

   // outcome of the shared slot unit
   typedef struct packed {
      logic      is_zero;
      entry_type dec_entry;
      entry_type reload_entry;
   } alu_result_type;

   // result fields gathered while a transaction is worked on
   typedef struct packed {
      logic              fired;
      logic [TAG_W-1:0]  fired_tag;
      logic [SLOT_W-1:0] fired_slot;
      logic              entry_lost;
   } result_type;

endpackage

/* sv/tts_chan_if.sv */
// request and response channel interfaces of the tick task scheduler table
interface tts_req_if;
   import tts_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          cmd;
   logic [TAG_W-1:0]    task_tag;
   logic [PERIOD_W-1:0] period_ticks;
   logic                repeat_req;
   logic [SLOT_W-1:0]   slot_index;

   modport source (output valid, cmd, task_tag, period_ticks, repeat_req, slot_index,
                   input ready);
   modport sink (input valid, cmd, task_tag, period_ticks, repeat_req, slot_index,
                 output ready);
endinterface

interface tts_rsp_if;
   import tts_pkg::*;

   logic               valid;
   logic               ready;
   logic               fired;
   logic [TAG_W-1:0]   fired_tag;
   logic [SLOT_W-1:0]  fired_slot;
   logic               entry_lost;
   logic [COUNT_W-1:0] task_count;

   modport source (output valid, fired, fired_tag, fired_slot, entry_lost, task_count,
                   input ready);
   modport sink (input valid, fired, fired_tag, fired_slot, entry_lost, task_count,
                 output ready);
endinterface

/* sv/tts_slot_alu.sv */
// shared slot unit: zero test, countdown decrement and reload of one entry
module tts_slot_alu (
   input  tts_pkg::entry_type      slot_entry,
   output tts_pkg::alu_result_type alu_out
);
   import tts_pkg::*;

   // zero compare and decrement share the countdown operand
   always_comb begin
      alu_out.is_zero                = (slot_entry.countdown == '0);
      alu_out.dec_entry              = slot_entry;
      alu_out.dec_entry.countdown    = slot_entry.countdown - PERIOD_W'(1);
      alu_out.reload_entry           = slot_entry;
      alu_out.reload_entry.countdown = slot_entry.period;
   end

endmodule

/* sv/tick_task_scheduler_table_core.sv */
// top level of the tick task scheduler table: sequencer, entry memory and result register
//
// The block keeps a packed table of timed tasks in an entry memory with one write and
// one read port; the occupied slots are always a prefix, tracked by a fill count, so no
// clearing pass is needed after reset or clear. Every transaction gives exactly one
// response. The sequencer visits a slot as a registered memory read, then the shared
// slot unit and a write back: a tick scans the occupied slots up to the first that
// fires, and a one-shot that fires moves every later occupied slot up; an add moves
// the occupied slots down (the last is dropped when full) and writes the new entry to
// slot 0; a remove moves every later occupied slot up; a clear resets the fill count.
// The next request is accepted once the sequencer is idle, even while the previous
// response still waits to be taken.
module tick_task_scheduler_table_core #(
   parameter int TABLE_SLOTS = tts_pkg::DEFAULT_TABLE_SLOTS
) (
   input logic       clock,
   input logic       reset,
   tts_req_if.sink   req_chan,
   tts_rsp_if.source rsp_chan
);
   import tts_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_SLOTS - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_EXEC = 3'd2;
   localparam logic [2:0] ST_WNEW = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic                repeat_ff, repeat_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   result_type          res_ff, res_in;
   result_type          out_ff, out_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;
   logic                out_valid_ff, out_valid_in;

   entry_type           mem_ff [TABLE_SLOTS];
   entry_type           rd_data_ff;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   entry_type           wr_data;
   entry_type           new_entry;
   alu_result_type      alu_out;

   logic                req_accept;
   logic [CNT_W-1:0]    idx_plus;
   logic                idx_more;
   logic                table_full;
   logic [CNT_W+2:0]    slot_ext;
   logic [CNT_W+2:0]    count_ext;
   logic [CNT_W+2:0]    slot_plus;
   logic [IDX_W+2:0]    idx_ext;
   logic [CNT_W+3:0]    count_out_ext;
   logic [IDX_W-1:0]    add_top;

   // shared slot unit on the registered read data
   tts_slot_alu u_slot_alu (
      .slot_entry (rd_data_ff),
      .alu_out    (alu_out)
   );

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[idx_ff];
   end

   // index and count arithmetic
   assign req_accept    = req_chan.valid && req_chan.ready;
   assign idx_plus      = CNT_W'(idx_ff) + CNT_W'(1);
   assign idx_more      = (idx_plus < count_ff);
   assign table_full    = (count_ff == FULL_COUNT);
   assign slot_ext      = {CNT_W'(0), req_chan.slot_index};
   assign count_ext     = {3'b000, count_ff};
   assign slot_plus     = slot_ext + (CNT_W + 3)'(1);
   assign idx_ext       = {3'b000, idx_ff};
   assign count_out_ext = {4'b0000, count_ff};
   assign add_top       = table_full ? LAST_IDX : count_ff[IDX_W-1:0];

   assign new_entry.tag         = tag_ff;
   assign new_entry.period      = period_ff;
   assign new_entry.countdown   = period_ff;
   assign new_entry.repeat_flag = repeat_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tag_in       = tag_ff;
      period_in    = period_ff;
      repeat_in    = repeat_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_count_in = out_count_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = alu_out.dec_entry;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = req_chan.cmd;
               tag_in    = req_chan.task_tag;
               period_in = req_chan.period_ticks;
               repeat_in = req_chan.repeat_req;
               res_in    = '0;
               state_in  = ST_DONE;
               unique case (req_chan.cmd)
                  CMD_TICK: begin
                     if (count_ff != '0) begin
                        idx_in   = '0;
                        state_in = ST_READ;
                     end
                  end
                  CMD_ADD: begin
                     res_in.entry_lost = table_full;
                     if (add_top == '0) begin
                        state_in = ST_WNEW;
                     end else begin
                        idx_in   = add_top - IDX_W'(1);
                        state_in = ST_READ;
                     end
                  end
                  CMD_REMOVE: begin
                     // slots beyond the fill count are empty: nothing to do
                     if (slot_ext < count_ext) begin
                        if (slot_plus < count_ext) begin
                           idx_in   = slot_plus[IDX_W-1:0];
                           state_in = ST_READ;
                        end else begin
                           count_in = count_ff - CNT_W'(1);
                        end
                     end
                  end
                  default: begin
                     count_in = '0;
                  end
               endcase
            end
         end

         ST_READ: begin
            state_in = ST_EXEC;
         end

         ST_EXEC: begin
            unique case (op_ff)
               CMD_TICK: begin
                  wr_en = 1'b1;
                  if (!alu_out.is_zero) begin
                     wr_data = alu_out.dec_entry;
                     if (idx_more) begin
                        idx_in   = idx_plus[IDX_W-1:0];
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end else begin
                     wr_data          = alu_out.reload_entry;
                     res_in.fired     = 1'b1;
                     res_in.fired_tag = rd_data_ff.tag;
                     res_in.fired_slot = idx_ext[2:0];
                     if (rd_data_ff.repeat_flag) begin
                        state_in = ST_DONE;
                     end else if (idx_more) begin
                        // one-shot: close the gap behind it
                        op_in    = CMD_REMOVE;
                        idx_in   = idx_plus[IDX_W-1:0];
                        state_in = ST_READ;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        state_in = ST_DONE;
                     end
                  end
               end
               CMD_ADD: begin
                  wr_en   = 1'b1;
                  wr_addr = idx_ff + IDX_W'(1);
                  wr_data = rd_data_ff;
                  if (idx_ff == '0) begin
                     state_in = ST_WNEW;
                  end else begin
                     idx_in   = idx_ff - IDX_W'(1);
                     state_in = ST_READ;
                  end
               end
               CMD_REMOVE: begin
                  wr_en   = 1'b1;
                  wr_addr = idx_ff - IDX_W'(1);
                  wr_data = rd_data_ff;
                  if (idx_more) begin
                     idx_in   = idx_plus[IDX_W-1:0];
                     state_in = ST_READ;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_WNEW: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = new_entry;
            count_in = table_full ? count_ff : count_ff + CNT_W'(1);
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // hand the result over once the output register is free
            if (!out_valid_ff || rsp_chan.ready) begin
               out_in       = res_ff;
               out_count_in = count_out_ext[COUNT_W-1:0];
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      tag_ff       <= tag_in;
      period_ff    <= period_in;
      repeat_ff    <= repeat_in;
      idx_ff       <= idx_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
      out_count_ff <= out_count_in;
   end

   // response channel
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.fired      = out_ff.fired;
   assign rsp_chan.fired_tag  = out_ff.fired_tag;
   assign rsp_chan.fired_slot = out_ff.fired_slot;
   assign rsp_chan.entry_lost = out_ff.entry_lost;
   assign rsp_chan.task_count = out_count_ff;

endmodule

/* sv/tts_checker.sv */
// port-level assertions of the tick task scheduler table and their bind
module tts_checker #(
   parameter int TABLE_SLOTS = tts_pkg::DEFAULT_TABLE_SLOTS
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_fired,
   input logic [tts_pkg::TAG_W-1:0]   rsp_fired_tag,
   input logic [tts_pkg::SLOT_W-1:0]  rsp_fired_slot,
   input logic                        rsp_entry_lost,
   input logic [tts_pkg::COUNT_W-1:0] rsp_task_count
);
   import tts_pkg::*;

   localparam logic [COUNT_W-1:0] FULL_LOW = COUNT_W'(TABLE_SLOTS);

   // a tick never drops an entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> !rsp_entry_lost)
      else $error("fired and entry_lost in one transaction");

   // no fire means zero tag and slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_fired_tag == '0 && rsp_fired_slot == '0)
      else $error("tag or slot reported without a fire");

   // a dropped entry leaves the table full
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_lost |-> rsp_task_count == FULL_LOW)
      else $error("entry lost but table not full");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fired) &&
         $stable(rsp_fired_tag) && $stable(rsp_fired_slot) &&
         $stable(rsp_entry_lost) && $stable(rsp_task_count))
      else $error("stalled response changed");

endmodule

bind tick_task_scheduler_table_core tts_checker #(
   .TABLE_SLOTS (TABLE_SLOTS)
) u_tts_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_fired      (rsp_chan.fired),
   .rsp_fired_tag  (rsp_chan.fired_tag),
   .rsp_fired_slot (rsp_chan.fired_slot),
   .rsp_entry_lost (rsp_chan.entry_lost),
   .rsp_task_count (rsp_chan.task_count)
);
